>>> rtl/phg_pkg.sv
package phg_pkg;

  // Pipeline depth: frame phases, frame factors, coordinate products,
  // wave phases, wave sines and the final hue sum.
  localparam int STAGES = 6;

  // Sine table geometry. The depth must be a power of two.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_W           = SINE_IDX_W - 2;

  // Pi/2 in Q30, used only while the table is built.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Frame phase rates in Q16 phase units per frame.
  localparam logic [31:0] K1_Q16 = 32'd7355802;
  localparam logic [31:0] K2_Q16 = 32'd43369938;

  // Q1.15 degrees to phase words: round(2^24 / 180).
  localparam logic [17:0] RECIP_Q24 = 18'd93207;

  // floor(2^28 / 45), for the half degree count to phase word mapping.
  localparam logic [22:0] RECIP_45 = 23'd5965232;
  localparam int          DIV_45   = 45;

  localparam int COORD_OFFSET = 5;
  localparam int HALF_DEG_MOD = 720;
  localparam int HUE_MOD      = 360;
  // Three wave offsets of 128 in Q8 plus the rounding half.
  localparam int HUE_BIAS     = 384 * 256 + 128;

  typedef logic [15:0]        phase_t;
  typedef logic signed [15:0] sample_t;
  typedef logic [14:0]        mag_t;
  typedef mag_t [QUARTER-1:0] quarter_rom_t;

  typedef struct packed {
    logic [STAGES-1:0] en;
  } pipe_ctrl_t;

  // Magnitude of sin(2*pi*j/DEPTH) for a first quadrant step j, by a
  // truncated Taylor series in Q30.
  function automatic mag_t sine_mag(input int j);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        t1;
    logic [63:0]        t2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    x    = (HALF_PI_Q30 * 64'(4 * j)) / 64'(SINE_TABLE_DEPTH);
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 7; k++) begin
      t1   = (term * x) >> 30;
      t2   = (t1 * x) >> 30;
      term = t2 / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    mag = 64'(sum + 64'sd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t rom;
    for (int j = 0; j < QUARTER; j++) begin
      rom[j] = sine_mag(j);
    end
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();
  localparam mag_t         PEAK_MAG    = sine_mag(QUARTER);

endpackage

>>> rtl/phg_pipe_ctrl.sv
module phg_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output phg_pkg::pipe_ctrl_t ctrl
);

  logic [phg_pkg::STAGES-1:0] valid;
  logic [phg_pkg::STAGES-1:0] valid_next;
  logic [phg_pkg::STAGES-1:0] stage_ready;
  logic [phg_pkg::STAGES-1:0] feed;

  // A stage can take a new request when it is empty or its content moves on.
  always_comb begin
    stage_ready[phg_pkg::STAGES-1] = !valid[phg_pkg::STAGES-1] || out_ready;
    for (int i = phg_pkg::STAGES - 2; i >= 0; i--) begin
      stage_ready[i] = !valid[i] || stage_ready[i+1];
    end
  end

  assign feed       = {valid[phg_pkg::STAGES-2:0], in_valid};
  assign valid_next = (stage_ready & feed) | (~stage_ready & valid);
  assign ctrl.en    = stage_ready & feed;
  assign in_ready   = stage_ready[0];
  assign out_valid  = valid[phg_pkg::STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  a_count_kept: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ($countones(valid) == $past($countones(valid))
              + int'($past(in_valid && in_ready))
              - int'($past(out_valid && out_ready))))
    else $error("request count in the pipeline is not conserved");

  a_full_stalled: assert property (@(posedge clk) disable iff (rst)
    ((&valid) && !out_ready) |-> !in_ready)
    else $error("full stalled pipeline still takes requests");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !ctrl.en[phg_pkg::STAGES-1])
    else $error("stalled result overwritten");

endmodule

>>> rtl/phg_sine_rom.sv
module phg_sine_rom (
  input  logic             clk,
  input  logic             en,
  input  phg_pkg::phase_t  phase,
  output phg_pkg::sample_t sample
);

  logic [phg_pkg::SINE_IDX_W-1:0] idx;
  logic [1:0]                     quad;
  logic [phg_pkg::QIDX_W-1:0]     step;
  logic [phg_pkg::QIDX_W-1:0]     addr;
  phg_pkg::mag_t                  mag;

  // Quarter wave table: odd quadrants run the table backwards, the lower
  // half plane negates.
  assign idx  = phase[15 -: phg_pkg::SINE_IDX_W];
  assign quad = idx[phg_pkg::SINE_IDX_W-1 -: 2];
  assign step = idx[phg_pkg::QIDX_W-1:0];
  assign addr = quad[0] ? (~step + 1'b1) : step;

  always_comb begin
    if (quad[0] && (step == '0)) begin
      mag = phg_pkg::PEAK_MAG;
    end else begin
      mag = phg_pkg::QUARTER_ROM[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

>>> rtl/phg_hue_sum.sv
module phg_hue_sum (
  input  logic             clk,
  input  logic             en,
  input  phg_pkg::sample_t v1,
  input  phg_pkg::sample_t v2,
  input  phg_pkg::sample_t v3,
  input  logic [7:0]       column_in,
  input  logic [7:0]       row_in,
  output logic [7:0]       column_out,
  output logic [7:0]       row_out,
  output logic [8:0]       hue
);

  logic signed [18:0] total;
  logic [9:0]         rounded;
  logic [8:0]         hue_next;

  assign total   = 19'(phg_pkg::HUE_BIAS) + 19'(v1) + 19'(v2) + 19'(v3);
  assign rounded = total[17:8];

  // The rounded sum stays below three turns, so two compares finish the modulo.
  always_comb begin
    if (rounded >= 10'(2 * phg_pkg::HUE_MOD)) begin
      hue_next = 9'(rounded - 10'(2 * phg_pkg::HUE_MOD));
    end else if (rounded >= 10'(phg_pkg::HUE_MOD)) begin
      hue_next = 9'(rounded - 10'(phg_pkg::HUE_MOD));
    end else begin
      hue_next = rounded[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue        <= hue_next;
      column_out <= column_in;
      row_out    <= row_in;
    end
  end

endmodule

>>> rtl/plasma_hue_pixel_generator_top.sv
// Plasma hue pixel generator: one hue per pixel request.
// Throughput is one request per cycle while the output is ready; the six
// register stages advance independently, so empty stages fill while a
// result waits at the output. Reset (rst, synchronous, active high) clears
// the stage valid bits only; the block keeps no other state.
module plasma_hue_pixel_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  column,
  input  logic [7:0]  row,
  input  logic [30:0] frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  column_out,
  output logic [7:0]  row_out,
  output logic [8:0]  hue
);

  phg_pkg::pipe_ctrl_t ctrl;

  phg_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // ---------------------------------------------------------------------
  // Stage 0: frame phases. Only the low 32 bits of each product matter,
  // since the phase word is bits 31:16 and wraps. The frame is also split
  // for the half degree count: frame mod 240 is built from frame mod 16 and
  // (frame >> 4) mod 15, the latter from a nibble sum.
  // ---------------------------------------------------------------------
  logic [31:0]     frame_k1;
  logic [31:0]     frame_k2;
  logic [6:0]      nib_sum;
  phg_pkg::phase_t ph1;
  phg_pkg::phase_t ph2;
  logic [6:0]      nib0;
  logic [3:0]      tlow0;
  logic [9:0]      xy0;
  logic [7:0]      col0;
  logic [7:0]      row0;

  assign frame_k1 = {1'b0, frame} * phg_pkg::K1_Q16;
  assign frame_k2 = {1'b0, frame} * phg_pkg::K2_Q16;

  always_comb begin
    nib_sum = 7'(frame[30:28]);
    for (int k = 0; k < 6; k++) begin
      nib_sum = nib_sum + 7'(frame[4 + 4 * k +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      ph1   <= frame_k1[31:16];
      ph2   <= -frame_k2[31:16];
      nib0  <= nib_sum;
      tlow0 <= frame[3:0];
      xy0   <= 10'(column) + 10'(row) + 10'(2 * phg_pkg::COORD_OFFSET);
      col0  <= column;
      row0  <= row;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: frame factors c1 and c2 from the sine table, and the half
  // degree count n = (x + y + 10 + 3t) mod 720.
  // ---------------------------------------------------------------------
  phg_pkg::sample_t c1;
  phg_pkg::sample_t c2;
  logic [4:0]       fold15;
  logic [3:0]       tmod15;
  logic [7:0]       tmod240;
  logic [10:0]      n_raw;
  logic [9:0]       n_next;
  logic [9:0]       n1;
  logic [7:0]       col1;
  logic [7:0]       row1;

  phg_sine_rom u_rom_c1 (.clk(clk), .en(ctrl.en[1]), .phase(ph1), .sample(c1));
  phg_sine_rom u_rom_c2 (.clk(clk), .en(ctrl.en[1]), .phase(ph2), .sample(c2));

  // Sixteen is one mod fifteen, so folding the nibble sum once more leaves
  // a value below 23, and a single subtraction finishes it.
  assign fold15  = 5'(nib0[6:4]) + 5'(nib0[3:0]);
  assign tmod15  = (fold15 >= 5'd15) ? 4'(fold15 - 5'd15) : fold15[3:0];
  assign tmod240 = {tmod15, tlow0};
  assign n_raw   = 11'(xy0) + 11'(tmod240) * 11'd3;
  assign n_next  = (n_raw >= 11'(phg_pkg::HALF_DEG_MOD))
                 ? 10'(n_raw - 11'(phg_pkg::HALF_DEG_MOD)) : n_raw[9:0];

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      n1   <= n_next;
      col1 <= col0;
      row1 <= row0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: coordinate times frame factor for waves one and two, and the
  // reciprocal estimate of n * 4096 / 45 for wave three.
  // ---------------------------------------------------------------------
  logic [8:0]         xc;
  logic [8:0]         yc;
  logic [32:0]        q_prod;
  logic signed [25:0] m1;
  logic signed [25:0] m2;
  logic [15:0]        q_est;
  logic [9:0]         n2;
  logic [7:0]         col2;
  logic [7:0]         row2;

  assign xc     = 9'(col1) + 9'(phg_pkg::COORD_OFFSET);
  assign yc     = 9'(row1) + 9'(phg_pkg::COORD_OFFSET);
  assign q_prod = 33'(n1) * 33'(phg_pkg::RECIP_45);

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      m1    <= $signed({1'b0, xc}) * c1;
      m2    <= $signed({1'b0, yc}) * c2;
      q_est <= q_prod[31:16];
      n2    <= n1;
      col2  <= col1;
      row2  <= row1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: scale to phase words. Waves one and two take bits 39:24 of the
  // signed product; wave three corrects the quotient estimate, which is at
  // most one short.
  // ---------------------------------------------------------------------
  logic signed [43:0] pa;
  logic signed [43:0] pb;
  logic [22:0]        q_rem;
  phg_pkg::phase_t    ph_a;
  phg_pkg::phase_t    ph_b;
  phg_pkg::phase_t    ph_c;
  logic [7:0]         col3;
  logic [7:0]         row3;

  assign pa    = m1 * $signed({1'b0, phg_pkg::RECIP_Q24});
  assign pb    = m2 * $signed({1'b0, phg_pkg::RECIP_Q24});
  assign q_rem = {1'b0, n2, 12'b0} - 23'(q_est) * 23'(phg_pkg::DIV_45);

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      ph_a <= pa[39:24];
      ph_b <= pb[39:24];
      ph_c <= (q_rem >= 23'(phg_pkg::DIV_45)) ? q_est + 16'd1 : q_est;
      col3 <= col2;
      row3 <= row2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: the three wave sines.
  // ---------------------------------------------------------------------
  phg_pkg::sample_t v1;
  phg_pkg::sample_t v2;
  phg_pkg::sample_t v3;
  logic [7:0]       col4;
  logic [7:0]       row4;

  phg_sine_rom u_rom_v1 (.clk(clk), .en(ctrl.en[4]), .phase(ph_a), .sample(v1));
  phg_sine_rom u_rom_v2 (.clk(clk), .en(ctrl.en[4]), .phase(ph_b), .sample(v2));
  phg_sine_rom u_rom_v3 (.clk(clk), .en(ctrl.en[4]), .phase(ph_c), .sample(v3));

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      col4 <= col3;
      row4 <= row3;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: sum, round and reduce to degrees; this is the output register.
  // ---------------------------------------------------------------------
  phg_hue_sum u_hue (
    .clk        (clk),
    .en         (ctrl.en[5]),
    .v1         (v1),
    .v2         (v2),
    .v3         (v3),
    .column_in  (col4),
    .row_in     (row4),
    .column_out (column_out),
    .row_out    (row_out),
    .hue        (hue)
  );

endmodule

>>> verif/tb_plasma_hue_pixel_generator_top.sv
class hue_scoreboard;

  localparam int              DEPTH         = phg_pkg::SINE_TABLE_DEPTH;
  localparam longint unsigned HALF_PI       = 64'd1686629713;
  localparam longint unsigned RATE1         = 64'd7355802;
  localparam longint unsigned RATE2         = 64'd43369938;
  localparam longint          DEG_TO_PHASE  = 93207;
  localparam int              OFFSET        = 5;
  localparam int              HALF_DEG_TURN = 720;
  localparam int              BIAS          = 384 * 256 + 128;
  localparam int              HUE_RANGE     = 360;

  typedef struct packed {
    logic [7:0]  column;
    logic [7:0]  row;
    logic [8:0]  hue;
    logic [30:0] frame;
  } pixel_hue_t;

  phg_pkg::sample_t sine_lut[DEPTH];
  pixel_hue_t       pending_hues[$];
  int unsigned      errors;
  int unsigned      requests;
  int unsigned      results;

  // The table is built the same way the hardware table is specified:
  // a truncated Taylor series on the folded first quadrant angle.
  function new();
    longint unsigned x;
    longint unsigned term;
    longint unsigned t1;
    longint unsigned t2;
    longint          sum;
    int unsigned     quad;
    int unsigned     rem;
    int unsigned     r;
    int              mag;
    errors   = 0;
    requests = 0;
    results  = 0;
    for (int i = 0; i < DEPTH; i++) begin
      quad = (4 * i) / DEPTH;
      rem  = (4 * i) % DEPTH;
      r    = (quad % 2 == 1) ? DEPTH - rem : rem;
      x    = (HALF_PI * r) / DEPTH;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        t1   = (term * x) >> 30;
        t2   = (t1 * x) >> 30;
        term = t2 / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      mag = int'((sum + 16384) >>> 15);
      if (mag > 32767) begin
        mag = 32767;
      end
      sine_lut[i] = 16'((quad >= 2) ? -mag : mag);
    end
  endfunction

  function phg_pkg::sample_t sine(input phg_pkg::phase_t phase);
    return sine_lut[phase[15 -: phg_pkg::SINE_IDX_W]];
  endfunction

  // Q1.15 factor times an offset coordinate, in degrees, mapped to a phase word.
  function phg_pkg::phase_t wave_phase(input int unsigned coord5,
                                       input phg_pkg::sample_t c);
    longint p;
    p = longint'(coord5) * longint'(c) * DEG_TO_PHASE;
    return 16'(p >>> 24);
  endfunction

  function logic [8:0] plasma_hue(input logic [7:0] x, input logic [7:0] y,
                                  input logic [30:0] t);
    longint unsigned  tt;
    longint unsigned  n;
    phg_pkg::phase_t  ph1;
    phg_pkg::phase_t  ph2;
    phg_pkg::phase_t  ph3;
    phg_pkg::sample_t c1;
    phg_pkg::sample_t c2;
    phg_pkg::sample_t v1;
    phg_pkg::sample_t v2;
    phg_pkg::sample_t v3;
    int unsigned      xc;
    int unsigned      yc;
    int               total;
    tt    = t;
    ph1   = 16'((tt * RATE1) >> 16);
    ph2   = 16'(64'd0 - ((tt * RATE2) >> 16));
    c1    = sine(ph1);
    c2    = sine(ph2);
    xc    = x + OFFSET;
    yc    = y + OFFSET;
    v1    = sine(wave_phase(xc, c1));
    v2    = sine(wave_phase(yc, c2));
    n     = (64'(xc) + 64'(yc) + 3 * tt) % HALF_DEG_TURN;
    ph3   = 16'((n * 65536) / HALF_DEG_TURN);
    v3    = sine(ph3);
    total = BIAS + v1 + v2 + v3;
    return 9'((total >>> 8) % HUE_RANGE);
  endfunction

  function void note_request(input logic [7:0] x, input logic [7:0] y,
                             input logic [30:0] t);
    pixel_hue_t expected;
    expected.column = x;
    expected.row    = y;
    expected.frame  = t;
    expected.hue    = plasma_hue(x, y, t);
    pending_hues.push_back(expected);
    requests++;
  endfunction

  function void check_result(input logic [7:0] x, input logic [7:0] y,
                             input logic [8:0] h);
    pixel_hue_t expected;
    results++;
    if (pending_hues.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected result: col %0d row %0d hue %0d", x, y, h);
      end
      return;
    end
    expected = pending_hues.pop_front();
    if (x !== expected.column || y !== expected.row || h !== expected.hue) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch for frame %0d: expected col %0d row %0d hue %0d,",
                 expected.frame, expected.column, expected.row, expected.hue);
        $display("  got col %0d row %0d hue %0d", x, y, h);
      end
    end
  endfunction

  function int unsigned outstanding();
    return pending_hues.size();
  endfunction

endclass

module tb_plasma_hue_pixel_generator_top;

  // The limit is many times the longest legal stretch without any handshake,
  // which comes from the long output hold and the pipeline depth.
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 64;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  column;
  logic [7:0]  row;
  logic [30:0] frame;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  column_out;
  logic [7:0]  row_out;
  logic [8:0]  hue;

  // Shared control between the stimulus and the output side. When idle_on
  // is clear neither side inserts random gaps; hold_request asks the output
  // side for one long stall.
  bit          idle_on;
  bit          hold_request;

  // Raster position used by the scan-like part of the random stimulus.
  logic [7:0]  scan_x;
  logic [7:0]  scan_y;
  logic [30:0] scan_t;

  hue_scoreboard hues;

  plasma_hue_pixel_generator_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .column     (column),
    .row        (row),
    .frame      (frame),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .column_out (column_out),
    .row_out    (row_out),
    .hue        (hue)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both handshakes are sampled at the rising edge. Inputs only change at
  // the falling edge, so the sampled values are stable here.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      hues.note_request(column, row, frame);
    end
    if (!rst && out_valid && out_ready) begin
      hues.check_result(column_out, row_out, hue);
    end
  end

  // Output side. Normally ready; random stalls of random length while
  // idling is enabled; one long stall on request, counted here.
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: the run fails if no request and no result moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // on return, so a following request goes out without a bubble.
  task automatic send_pixel(input logic [7:0] x, input logic [7:0] y,
                            input logic [30:0] t);
    @(negedge clk);
    in_valid <= 1'b1;
    column   <= x;
    row      <= y;
    frame    <= t;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Random requests: a quarter fully random over all bits, a quarter with
  // early frame numbers, and half walking a raster the way a display scan
  // does, moving to the next frame now and then.
  task automatic send_random(input int unsigned count);
    logic [7:0]  x;
    logic [7:0]  y;
    logic [30:0] t;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          x = 8'($urandom);
          y = 8'($urandom);
          t = 31'($urandom);
        end
        1: begin
          x = 8'($urandom);
          y = 8'($urandom);
          t = 31'($urandom_range(0, 2000));
        end
        default: begin
          x      = scan_x;
          y      = scan_y;
          t      = scan_t;
          scan_x = scan_x + 8'd1;
          if (scan_x == 8'd0) begin
            scan_y = scan_y + 8'd1;
          end
          if ($urandom_range(0, 63) == 0) begin
            scan_t = scan_t + 31'd1;
          end
        end
      endcase
      send_pixel(x, y, t);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_idle();
        end
      end
    end
  endtask

  initial begin
    hues         = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    column       = 8'd0;
    row          = 8'd0;
    frame        = 31'd0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    scan_x       = 8'd0;
    scan_y       = 8'd0;
    scan_t       = 31'd1;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed requests: coordinate corners, frame zero where both frame
    // factors vanish, the first frame, the largest frame number where every
    // phase wraps, and a few patterned frame values.
    send_pixel(8'd0,   8'd0,   31'd0);
    send_pixel(8'd255, 8'd255, 31'd0);
    send_pixel(8'd0,   8'd0,   31'd1);
    send_pixel(8'd255, 8'd0,   31'd1);
    send_pixel(8'd0,   8'd255, 31'd1);
    send_pixel(8'd255, 8'd255, 31'h7FFF_FFFF);
    send_pixel(8'd0,   8'd0,   31'h7FFF_FFFF);
    send_pixel(8'd128, 8'd64,  31'd12345);
    send_pixel(8'd1,   8'd1,   31'd584);
    send_pixel(8'd254, 8'd253, 31'd1000000);
    send_pixel(8'd255, 8'd255, 31'h4000_0000);
    send_pixel(8'd0,   8'd0,   31'h5555_5555);
    send_pixel(8'd170, 8'd85,  31'h2AAA_AAAA);
    send_pixel(8'd17,  8'd200, 31'd360);
    send_pixel(8'd99,  8'd7,   31'd240);

    send_random(800);

    // Let the pipeline run completely dry before going on.
    send_idle();
    while (hues.outstanding() != 0) begin
      @(posedge clk);
    end

    // Long output stall while requests keep coming back to back, so the
    // pipeline fills and the input side is held off.
    idle_on      = 1'b0;
    hold_request = 1'b1;
    send_random(40);

    idle_on = 1'b1;
    send_random(700);

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    send_random(300);
    send_idle();

    while (hues.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (phg_pkg::STAGES + 4) @(posedge clk);

    $display("Checked %0d hues for %0d pixel requests: corners, extreme frames,",
             hues.results, hues.requests);
    $display("raster scans, random stalls, a long output stall and a full drain.");
    if (hues.errors == 0 && hues.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/phg_pkg.sv
rtl/phg_pipe_ctrl.sv
rtl/phg_sine_rom.sv
rtl/phg_hue_sum.sv
rtl/plasma_hue_pixel_generator_top.sv
verif/tb_plasma_hue_pixel_generator_top.sv
